FILE: rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int RING_SLOTS_DEF = 8;

    localparam int FIELD_W    = 3;
    localparam int FUNC_W     = 2;
    localparam int INTERVAL_W = 8;
    localparam int COUNT_W    = 4;
    localparam int SWITCH_W   = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd12;
    localparam int MIN_ACTIVE = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_REG   = 2'd1,
        FUNC_UNREG = 2'd2
    } func_t;

    // Result item, lowest field last so the packed order matches m_tdata.
    typedef struct packed {
        logic [SWITCH_W-1:0] switches_done;
        logic [COUNT_W-1:0]  valid_count;
        logic [FIELD_W-1:0]  next_wing;
        logic [FIELD_W-1:0]  next_context;
        logic [FIELD_W-1:0]  next_agent_id;
        logic [FIELD_W-1:0]  prev_entry;
        logic [FIELD_W-1:0]  current_entry;
        logic                rotated;
        logic                ok;
    } res_t;

    localparam int RES_W      = $bits(res_t);
    localparam int RES_BYTES  = (RES_W + 7) / 8;
    localparam int IN_DATA_W  = 3 * FIELD_W;
    localparam int IN_BYTES   = (IN_DATA_W + 7) / 8;

endpackage

FILE: rtl/rrts_next_valid.sv
`timescale 1ns / 1ps

module rrts_next_valid
    import rrts_pkg::*;
#(
    parameter int SLOTS = RING_SLOTS_DEF
) (
    input  logic [SLOTS-1:0]         valid,
    input  logic [$clog2(SLOTS)-1:0] from,
    output logic                     found,
    output logic [$clog2(SLOTS)-1:0] idx
);

    localparam int PW = $clog2(SLOTS);
    localparam int SW = PW + 2;

    logic [SW-1:0] slot [SLOTS];

    // Ring order after the start slot; the sum stays below twice the ring size.
    always_comb begin
        for (int k = 1; k <= SLOTS; k++) begin
            slot[k-1] = SW'(from) + SW'(k);
            if (slot[k-1] >= SW'(SLOTS)) begin
                slot[k-1] = slot[k-1] - SW'(SLOTS);
            end
        end
    end

    // Scan from the far end so the nearest valid slot wins.
    always_comb begin
        found = 1'b0;
        idx   = from;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (valid[slot[k][PW-1:0]]) begin
                found = 1'b1;
                idx   = slot[k][PW-1:0];
            end
        end
    end

endmodule

FILE: rtl/rrts_sched.sv
`timescale 1ns / 1ps

module rrts_sched
    import rrts_pkg::*;
#(
    parameter int SLOTS = RING_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  cfg_wr_en,
    input  logic [INTERVAL_W-1:0] cfg_wr_data,
    input  logic                  fire,
    input  logic [FUNC_W-1:0]     func,
    input  logic [FIELD_W-1:0]    agent_id,
    input  logic [FIELD_W-1:0]    context_num,
    input  logic [FIELD_W-1:0]    wing_num,
    output res_t                  res
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]      valid_reg, valid_next, clr_valid;
    logic [FIELD_W-1:0]    id_reg   [SLOTS];
    logic [FIELD_W-1:0]    ctx_reg  [SLOTS];
    logic [FIELD_W-1:0]    wing_reg [SLOTS];
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [INTERVAL_W-1:0] tick_reg, tick_next, tick_inc;
    logic [SWITCH_W-1:0]   sw_reg, sw_next;
    logic [INTERVAL_W-1:0] interval_reg;

    logic          has_free, has_match, wr_en, ok, rot;
    logic [PW-1:0] free_idx, match_idx;
    logic          tk_found, un_found;
    logic [PW-1:0] tk_idx, un_idx;
    logic [FIELD_W-1:0] rd_id, rd_ctx, rd_wing;
    logic [31:0]   ptr_wide, prev_wide, cnt_wide;

    // Lowest free slot and lowest valid slot with a matching id.
    always_comb begin
        has_free  = 1'b0;
        free_idx  = '0;
        has_match = 1'b0;
        match_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                has_free = 1'b1;
                free_idx = PW'(i);
            end
            if (valid_reg[i] && id_reg[i] == agent_id) begin
                has_match = 1'b1;
                match_idx = PW'(i);
            end
        end
    end

    always_comb begin
        clr_valid = valid_reg;
        clr_valid[match_idx] = 1'b0;
    end

    rrts_next_valid #(.SLOTS(SLOTS)) u_tick_pick (
        .valid (valid_reg),
        .from  (ptr_reg),
        .found (tk_found),
        .idx   (tk_idx)
    );

    rrts_next_valid #(.SLOTS(SLOTS)) u_unreg_pick (
        .valid (clr_valid),
        .from  (match_idx),
        .found (un_found),
        .idx   (un_idx)
    );

    assign tick_inc = tick_reg + 8'd1;

    always_comb begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        tick_next  = tick_reg;
        sw_next    = sw_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        ok         = 1'b0;
        rot        = 1'b0;
        unique case (func_t'(func))
            FUNC_TICK: begin
                if (cnt_reg >= CW'(MIN_ACTIVE)) begin
                    tick_next = tick_inc;
                    if (tick_inc >= interval_reg) begin
                        tick_next = '0;
                        if (tk_found && tk_idx != ptr_reg) begin
                            ptr_next = tk_idx;
                            sw_next  = sw_reg + 32'd1;
                            ok       = 1'b1;
                            rot      = 1'b1;
                        end
                    end
                end
            end
            FUNC_REG: begin
                if (has_free) begin
                    valid_next[free_idx] = 1'b1;
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    ok       = 1'b1;
                end
            end
            FUNC_UNREG: begin
                if (has_match) begin
                    valid_next = clr_valid;
                    cnt_next   = cnt_reg - CW'(1);
                    if (ptr_reg == match_idx && un_found) begin
                        ptr_next = un_idx;
                    end
                    ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Read the running slot as it stands after this item.
    always_comb begin
        rd_id   = '0;
        rd_ctx  = '0;
        rd_wing = '0;
        if (valid_next[ptr_next]) begin
            if (wr_en && free_idx == ptr_next) begin
                rd_id   = agent_id;
                rd_ctx  = context_num;
                rd_wing = wing_num;
            end else begin
                rd_id   = id_reg[ptr_next];
                rd_ctx  = ctx_reg[ptr_next];
                rd_wing = wing_reg[ptr_next];
            end
        end
    end

    assign ptr_wide  = 32'(ptr_next);
    assign prev_wide = 32'(ptr_reg);
    assign cnt_wide  = 32'(cnt_next);

    always_comb begin
        res.ok            = ok;
        res.rotated       = rot;
        res.current_entry = ptr_wide[FIELD_W-1:0];
        res.prev_entry    = prev_wide[FIELD_W-1:0];
        res.next_agent_id = rd_id;
        res.next_context  = rd_ctx;
        res.next_wing     = rd_wing;
        res.valid_count   = cnt_wide[COUNT_W-1:0];
        res.switches_done = sw_next;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            tick_reg     <= '0;
            sw_reg       <= '0;
            interval_reg <= INTERVAL_RST;
        end else begin
            if (cfg_wr_en) begin
                interval_reg <= cfg_wr_data;
            end
            if (fire) begin
                valid_reg <= valid_next;
                cnt_reg   <= cnt_next;
                ptr_reg   <= ptr_next;
                tick_reg  <= tick_next;
                sw_reg    <= sw_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (fire && wr_en) begin
            id_reg[free_idx]   <= agent_id;
            ctx_reg[free_idx]  <= context_num;
            wing_reg[free_idx] <= wing_num;
        end
    end

endmodule

FILE: rtl/round_robin_time_slice_scheduler_core.sv
`timescale 1ns / 1ps
// Round-robin time-slice scheduler over a ring of agent slots.
// Input channel s_*: s_tuser carries the operation (tick, register slot,
// unregister slot), s_tdata the agent id, context and wing. Every item gives
// exactly one result item on m_*: status flags, the running slot before and
// after the item with its id, context and wing, the number of valid slots and
// the running total of rotations.
// The rotation interval is set through cfg_wr_en/cfg_wr_data; write it only
// while no item is in flight. Reset sets it to 12 ticks.
// An accepted item goes into the input register; the result register loads
// from the combinational slot-table update once it is free or being taken,
// and m_tvalid rises with it. Throughput: one item per cycle while
// m_tready is high, set by the single-pass table update between registers.
// Reset clears all slots, the pointer, the tick counter and the switch count.
// When m_tready is low the result is held; one more item is taken into the
// input register, after which s_tready drops until the result is taken.

module round_robin_time_slice_scheduler_core
    import rrts_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [INTERVAL_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] agent_id, [5:3] context_num, [8:6] wing_num
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    // [1:0] func
    input  logic [FUNC_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [1] rotated, [4:2] current_entry, [7:5] prev_entry,
    // [10:8] next_agent_id, [13:11] next_context, [16:14] next_wing,
    // [20:17] valid_count, [52:21] switches_done
    output logic [RES_BYTES*8-1:0] m_tdata
);

    logic               in_vld_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [FIELD_W-1:0] aid_reg, ctx_reg, wing_reg;
    logic               out_vld_reg;
    res_t               out_res_reg;
    res_t               res;
    logic               adv;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            func_reg <= s_tuser;
            aid_reg  <= s_tdata[FIELD_W-1:0];
            ctx_reg  <= s_tdata[2*FIELD_W-1:FIELD_W];
            wing_reg <= s_tdata[3*FIELD_W-1:2*FIELD_W];
        end
    end

    rrts_sched #(.SLOTS(RING_SLOTS)) u_sched (
        .clk         (aclk),
        .rstn        (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (adv),
        .func        (func_reg),
        .agent_id    (aid_reg),
        .context_num (ctx_reg),
        .wing_num    (wing_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = (RES_BYTES*8)'(out_res_reg);

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_adv_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_vld_reg)
        else $error("advanced item did not reach the result register");

    a_rot_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (!out_res_reg.rotated || out_res_reg.ok))
        else $error("rotation reported without ok");

endmodule
